[hw/rtl/wifi_ie_rate_capability_fingerprint_assert.svh]
// Assertion macros used by the checker file of the fingerprint block
`ifndef WIFI_IE_RATE_CAPABILITY_FINGERPRINT_ASSERT_SVH
`define WIFI_IE_RATE_CAPABILITY_FINGERPRINT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WIEFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WIEFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wiefp_pkg.sv]
// Types, constants and limits of the information element fingerprint block
package wiefp_pkg;

  localparam int RATE_LIMIT    = 8;
  localparam int MAX_CAP_BYTES = 8;
  localparam int PACK_BYTES    = 8;

  localparam int RATE_CNT_W = $clog2(RATE_LIMIT + 1);
  localparam int CAP_CNT_W  = $clog2(MAX_CAP_BYTES + 1);
  localparam int RATE_IDX_W = (RATE_LIMIT > 1) ? $clog2(RATE_LIMIT) : 1;
  localparam int CAP_IDX_W  = (MAX_CAP_BYTES > 1) ? $clog2(MAX_CAP_BYTES) : 1;

  // Tag ids
  localparam logic [7:0] TAG_RATES     = 8'd1;
  localparam logic [7:0] TAG_EXT_RATES = 8'd50;
  localparam logic [7:0] TAG_EXT_CAP   = 8'd127;

  // Known vendor prefixes
  localparam logic [23:0] OUI_A = 24'h4C776D;
  localparam logic [23:0] OUI_B = 24'hB827EB;
  localparam logic [23:0] OUI_C = 24'h001A2B;
  localparam logic [23:0] OUI_D = 24'hAC220B;

  // Rate count thresholds
  localparam int LAPTOP_RATES = 8;
  localparam int PHONE_RATES  = 4;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } parse_phase_t;

  typedef enum logic [2:0] {
    DC_UNKNOWN = 3'd0,
    DC_PHONE   = 3'd1,
    DC_LAPTOP  = 3'd2,
    DC_IOT     = 3'd3,
    DC_AP      = 3'd4,
    DC_ROUTER  = 3'd5
  } device_class_t;

  typedef enum logic [2:0] {
    VH_NONE  = 3'd0,
    VH_OUI_A = 3'd1,
    VH_OUI_B = 3'd2,
    VH_OUI_C = 3'd3,
    VH_OUI_D = 3'd4
  } vendor_hint_t;

  // Frame summary after the current item has been parsed
  typedef struct packed {
    logic [RATE_CNT_W-1:0] rate_total;
    logic [63:0]           rates_packed;
    logic [CAP_CNT_W-1:0]  cap_count;
    logic [63:0]           cap_packed;
  } summary_t;

endpackage

[hw/rtl/wiefp_channels.sv]
// Valid/ready channel interfaces for frame bytes and fingerprint reports
interface wiefp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ie_byte;
  logic        has_byte;
  logic        frame_end;
  logic [23:0] vendor_oui;

  modport source (output valid, ie_byte, has_byte, frame_end, vendor_oui, input ready);
  modport sink (input valid, ie_byte, has_byte, frame_end, vendor_oui, output ready);
endinterface

interface wiefp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  device_class;
  logic [2:0]  vendor_hint;
  logic [3:0]  rate_tally;
  logic [63:0] rates_packed;
  logic [3:0]  ext_cap_count;
  logic [63:0] ext_cap_packed;

  modport source (output valid, device_class, vendor_hint, rate_tally, rates_packed,
                  ext_cap_count, ext_cap_packed, input ready);
  modport sink (input valid, device_class, vendor_hint, rate_tally, rates_packed,
                ext_cap_count, ext_cap_packed, output ready);
endinterface

[hw/rtl/wiefp_parser.sv]
// Tag parser: walks id/length/body, gathers rate and capability bytes
module wiefp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        ie_byte,
  input  logic              has_byte,
  input  logic              frame_end,
  output wiefp_pkg::summary_t summary
);
  import wiefp_pkg::*;

  parse_phase_t          phase, phase_next;
  logic [7:0]            tag_id, tag_id_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [7:0]            rate_store [RATE_LIMIT];
  logic [7:0]            rate_store_next [RATE_LIMIT];
  logic [RATE_CNT_W-1:0] rate_total, rate_total_next;
  logic [RATE_CNT_W-1:0] rate_pending, rate_pending_next;
  logic [7:0]            cap_store [MAX_CAP_BYTES];
  logic [7:0]            cap_store_next [MAX_CAP_BYTES];
  logic [CAP_CNT_W-1:0]  cap_total, cap_total_next;
  logic                  cap_seen, cap_seen_next;

  logic                  is_rate;
  logic                  is_cap;
  logic                  finish;
  logic [RATE_CNT_W-1:0] rate_pos;
  logic [CAP_CNT_W-1:0]  cap_count;

  assign is_rate  = (tag_id == TAG_RATES) || (tag_id == TAG_EXT_RATES);
  assign is_cap   = (tag_id == TAG_EXT_CAP) && !cap_seen;
  assign rate_pos = rate_total + rate_pending;

  // Parse one byte into the next tag state
  always_comb begin
    phase_next        = phase;
    tag_id_next       = tag_id;
    bytes_left_next   = bytes_left;
    rate_store_next   = rate_store;
    rate_total_next   = rate_total;
    rate_pending_next = rate_pending;
    cap_store_next    = cap_store;
    cap_total_next    = cap_total;
    cap_seen_next     = cap_seen;
    finish            = 1'b0;

    if (has_byte) begin
      unique case (phase)
        PH_ID: begin
          tag_id_next = ie_byte;
          phase_next  = PH_LEN;
        end
        PH_LEN: begin
          bytes_left_next   = ie_byte;
          rate_pending_next = '0;
          if (is_cap) begin
            cap_total_next = '0;
          end
          if (ie_byte == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_rate) begin
            if (int'(rate_pos) < RATE_LIMIT) begin
              rate_store_next[rate_pos[RATE_IDX_W-1:0]] = ie_byte;
              rate_pending_next = rate_pending + RATE_CNT_W'(1);
            end
          end else if (is_cap) begin
            if (int'(cap_total) < MAX_CAP_BYTES) begin
              cap_store_next[cap_total[CAP_IDX_W-1:0]] = ie_byte;
              cap_total_next = cap_total + CAP_CNT_W'(1);
            end
          end
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_next = PH_ID;
        end
      endcase
    end

    // Commit a complete tag
    if (finish) begin
      if (is_rate) begin
        rate_total_next = rate_total + rate_pending_next;
      end else if (is_cap) begin
        cap_seen_next = 1'b1;
      end
      rate_pending_next = '0;
      phase_next        = PH_ID;
    end
  end

  assign cap_count = cap_seen_next ? cap_total_next : '0;

  // Pack kept bytes, zero beyond the count
  always_comb begin
    summary.rate_total   = rate_total_next;
    summary.cap_count    = cap_count;
    summary.rates_packed = '0;
    summary.cap_packed   = '0;
    for (int i = 0; i < PACK_BYTES; i++) begin
      if (i < RATE_LIMIT && int'(rate_total_next) > i) begin
        summary.rates_packed[8*i +: 8] = rate_store_next[i];
      end
      if (i < MAX_CAP_BYTES && int'(cap_count) > i) begin
        summary.cap_packed[8*i +: 8] = cap_store_next[i];
      end
    end
  end

  // Hold parser state; clear it at reset and after each frame
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      phase        <= PH_ID;
      tag_id       <= '0;
      bytes_left   <= '0;
      rate_total   <= '0;
      rate_pending <= '0;
      cap_total    <= '0;
      cap_seen     <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      tag_id       <= tag_id_next;
      bytes_left   <= bytes_left_next;
      rate_total   <= rate_total_next;
      rate_pending <= rate_pending_next;
      cap_total    <= cap_total_next;
      cap_seen     <= cap_seen_next;
    end
  end

  // Byte stores carry payload only; reads are masked by the counts
  always_ff @(posedge clk) begin
    if (accept) begin
      rate_store <= rate_store_next;
      cap_store  <= cap_store_next;
    end
  end

endmodule

[hw/rtl/wiefp_classify.sv]
// Vendor and rate classification with the report output register
module wiefp_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [23:0]         vendor_oui,
  input  wiefp_pkg::summary_t summary,
  output logic                free,
  wiefp_out_if.source         report
);
  import wiefp_pkg::*;

  device_class_t cls;
  vendor_hint_t  hint;

  // Match known prefixes first, then fall back on rate count
  always_comb begin
    hint = VH_NONE;
    cls  = DC_UNKNOWN;
    if (vendor_oui == OUI_A) begin
      hint = VH_OUI_A;
      cls  = DC_PHONE;
    end else if (vendor_oui == OUI_B) begin
      hint = VH_OUI_B;
      cls  = DC_PHONE;
    end else if (vendor_oui == OUI_C) begin
      hint = VH_OUI_C;
      cls  = DC_AP;
    end else if (vendor_oui == OUI_D) begin
      hint = VH_OUI_D;
      cls  = DC_IOT;
    end else if (int'(summary.rate_total) >= LAPTOP_RATES) begin
      cls = DC_LAPTOP;
    end else if (int'(summary.rate_total) >= PHONE_RATES) begin
      cls = DC_PHONE;
    end
  end

  assign free = !report.valid || report.ready;

  // Hold the report until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report.device_class   <= cls;
      report.vendor_hint    <= hint;
      report.rate_tally     <= 4'(summary.rate_total);
      report.rates_packed   <= summary.rates_packed;
      report.ext_cap_count  <= 4'(summary.cap_count);
      report.ext_cap_packed <= summary.cap_packed;
    end
  end

endmodule

[hw/rtl/wifi_ie_rate_capability_fingerprint.sv]
// Top level: information element parser feeding the fingerprint report register
// The report is registered: valid in the cycle after the frame_end item is taken.
// Throughput: one item per cycle unless stalled; parser registers load on accept.
// Input stalls only while a finished report waits and the sink holds ready low.
// Reset (synchronous, rst high) returns the parser to expecting a tag id with all
// counts cleared and drops the report valid.
module wifi_ie_rate_capability_fingerprint (
  input  logic        clk,
  input  logic        rst,
  wiefp_in_if.sink    frame_bytes,
  wiefp_out_if.source report
);
  import wiefp_pkg::*;

  logic     free;
  logic     accept;
  summary_t summary;

  assign frame_bytes.ready = free;
  assign accept            = frame_bytes.valid && free;

  wiefp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ie_byte   (frame_bytes.ie_byte),
    .has_byte  (frame_bytes.has_byte),
    .frame_end (frame_bytes.frame_end),
    .summary   (summary)
  );

  wiefp_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && frame_bytes.frame_end),
    .vendor_oui (frame_bytes.vendor_oui),
    .summary    (summary),
    .free       (free),
    .report     (report)
  );

endmodule

[hw/rtl/wiefp_checker.sv]
// Port-level checker for the fingerprint block, bound to the top level
`include "wifi_ie_rate_capability_fingerprint_assert.svh"

module wiefp_checker (
  input logic       clk,
  input logic       rst,
  wiefp_in_if.sink  frame_bytes,
  wiefp_out_if.source report
);

  // Report stays up while stalled
  `WIEFP_ASSERT_NEXT(a_report_hold, clk, rst, report.valid && !report.ready, report.valid, "report dropped while stalled")

  // A frame end item always yields a report next cycle
  `WIEFP_ASSERT_NEXT(a_frame_end_report, clk, rst, frame_bytes.valid && frame_bytes.ready && frame_bytes.frame_end, report.valid, "no report after frame end")

  // A new report only follows an accepted frame end item
  `WIEFP_ASSERT_SAME(a_report_cause, clk, rst, $rose(report.valid), $past(frame_bytes.valid && frame_bytes.ready && frame_bytes.frame_end), "report without frame end")

  // Input is open whenever no report waits
  `WIEFP_ASSERT_SAME(a_ready_when_empty, clk, rst, !report.valid, frame_bytes.ready, "input stalled with empty output")

endmodule

bind wifi_ie_rate_capability_fingerprint wiefp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_bytes (frame_bytes),
  .report      (report)
);
